/* sv/spt_pkg.sv */
// shared types, character codes and tag tables for the sentence/paragraph tagger
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spt_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_PERIOD  = 8'd46;
    localparam logic [7:0] CH_EXCLAIM = 8'd33;
    localparam logic [7:0] CH_QUEST   = 8'd63;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LT      = 8'd60;
    localparam logic [7:0] CH_GT      = 8'd62;
    localparam logic [7:0] CH_SLASH   = 8'd47;
    localparam logic [7:0] CH_P       = 8'd112;

    // output segments, in emission order
    localparam int NUM_SEG = 6;
    localparam logic [2:0] SEG_OPEN0 = 3'd0;
    localparam logic [2:0] SEG_CLOSE = 3'd1;
    localparam logic [2:0] SEG_X     = 3'd2;
    localparam logic [2:0] SEG_OPEN1 = 3'd3;
    localparam logic [2:0] SEG_Y     = 3'd4;
    localparam logic [2:0] SEG_OPEN2 = 3'd5;

    typedef struct packed {
        logic [NUM_SEG-1:0] en;
        logic [7:0]         x;
        logic [7:0]         y;
    } t_desc;

    function automatic logic [7:0] open_byte(input logic [1:0] sub);
        logic [7:0] b;
        case (sub)
            2'd0:    b = CH_LT;
            2'd1:    b = CH_P;
            default: b = CH_GT;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] close_byte(input logic [1:0] sub);
        logic [7:0] b;
        case (sub)
            2'd0:    b = CH_LT;
            2'd1:    b = CH_SLASH;
            2'd2:    b = CH_P;
            default: b = CH_GT;
        endcase
        return b;
    endfunction

    function automatic logic is_break(input logic [7:0] b);
        return (b == CH_CR) || (b == CH_LF);
    endfunction

endpackage

`default_nettype wire

/* sv/spt_front.sv */
// front end: accepts items, tracks scan state, builds at most one segment descriptor per item
// uses spt_pkg
`timescale 1ns / 1ps
`default_nettype none

module spt_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_char,
    input  wire logic           i_end,
    input  wire logic           i_space,
    output logic                o_ready,
    output logic                o_push,
    output spt_pkg::t_desc      o_desc
);

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_PUNCT = 2'd1,
        MODE_BREAK = 2'd2
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [7:0] r_held, n_held;
    logic       r_started, n_started;
    logic       w_accept;
    spt_pkg::t_desc w_desc;

    assign o_ready  = i_space;
    assign w_accept = i_valid && i_space;

    always_comb begin
        w_desc    = '0;
        n_mode    = r_mode;
        n_held    = r_held;
        n_started = 1'b1;
        w_desc.en[spt_pkg::SEG_OPEN0] = !r_started;
        if (i_end) begin
            case (r_mode)
                MODE_PUNCT: w_desc.en[spt_pkg::SEG_CLOSE] = 1'b1;
                MODE_BREAK: begin
                    w_desc.en[spt_pkg::SEG_X] = 1'b1;
                    w_desc.x = r_held;
                end
                default: ;
            endcase
            n_mode    = MODE_TEXT;
            n_held    = '0;
            n_started = 1'b0;
        end else begin
            case (r_mode)
                MODE_PUNCT: begin
                    w_desc.x = i_char;
                    w_desc.en[spt_pkg::SEG_X] = 1'b1;
                    if (i_char == spt_pkg::CH_SPACE || spt_pkg::is_break(i_char)) begin
                        w_desc.en[spt_pkg::SEG_CLOSE] = 1'b1;
                        w_desc.en[spt_pkg::SEG_OPEN2] = 1'b1;
                    end
                    n_mode = MODE_TEXT;
                end
                MODE_BREAK: begin
                    w_desc.x = r_held;
                    w_desc.y = i_char;
                    w_desc.en[spt_pkg::SEG_X] = 1'b1;
                    w_desc.en[spt_pkg::SEG_Y] = 1'b1;
                    if (i_char >= spt_pkg::CH_UPPER_A && i_char <= spt_pkg::CH_UPPER_Z) begin
                        w_desc.en[spt_pkg::SEG_CLOSE] = 1'b1;
                        w_desc.en[spt_pkg::SEG_OPEN1] = 1'b1;
                    end else if (spt_pkg::is_break(i_char)) begin
                        w_desc.en[spt_pkg::SEG_CLOSE] = 1'b1;
                        w_desc.en[spt_pkg::SEG_OPEN2] = 1'b1;
                    end
                    n_held = '0;
                    n_mode = MODE_TEXT;
                end
                default: begin
                    if (spt_pkg::is_break(i_char)) begin
                        n_held = i_char;
                        n_mode = MODE_BREAK;
                    end else begin
                        w_desc.x = i_char;
                        w_desc.en[spt_pkg::SEG_X] = 1'b1;
                        if (i_char == spt_pkg::CH_PERIOD || i_char == spt_pkg::CH_EXCLAIM
                            || i_char == spt_pkg::CH_QUEST) begin
                            n_mode = MODE_PUNCT;
                        end else begin
                            n_mode = MODE_TEXT;
                        end
                    end
                end
            endcase
        end
    end

    assign o_desc = w_desc;
    assign o_push = w_accept && (w_desc.en != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_TEXT;
            r_held    <= '0;
            r_started <= 1'b0;
        end else if (w_accept) begin
            r_mode    <= n_mode;
            r_held    <= n_held;
            r_started <= n_started;
        end
    end

endmodule

`default_nettype wire

/* sv/spt_queue.sv */
// small descriptor queue between the front and back ends
// uses spt_pkg
`timescale 1ns / 1ps
`default_nettype none

module spt_queue #(
    parameter int DEPTH = spt_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire spt_pkg::t_desc i_desc,
    input  wire logic           i_pop,
    output logic                o_space,
    output logic                o_valid,
    output spt_pkg::t_desc      o_desc
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    spt_pkg::t_desc   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_space = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_space;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/spt_back.sv */
// back end: walks the segments of the head descriptor, one output byte per cycle unless the output is stalled
// uses spt_pkg
`timescale 1ns / 1ps
`default_nettype none

module spt_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_head_valid,
    input  wire spt_pkg::t_desc i_head,
    output logic                o_pop,
    output logic                o_tvalid,
    input  wire logic           i_tready,
    output logic [7:0]          o_tdata,
    output logic                o_tlast
);

    logic [spt_pkg::NUM_SEG-1:0] r_done;
    logic [1:0]                  r_sub;
    logic                        r_valid;
    logic [7:0]                  r_data;
    logic                        r_last;

    logic [spt_pkg::NUM_SEG-1:0] w_pend, w_seg_bit, w_rest;
    logic [2:0]                  w_seg;
    logic [1:0]                  w_len_m1;
    logic [7:0]                  w_byte;
    logic                        w_seg_end, w_fire, w_last;

    always_comb begin
        w_pend = i_head.en & ~r_done;
        w_seg  = '0;
        for (int i = spt_pkg::NUM_SEG - 1; i >= 0; i--) begin
            if (w_pend[i]) w_seg = 3'(i);
        end
        case (w_seg)
            spt_pkg::SEG_CLOSE: begin
                w_len_m1 = 2'd3;
                w_byte   = spt_pkg::close_byte(r_sub);
            end
            spt_pkg::SEG_X: begin
                w_len_m1 = 2'd0;
                w_byte   = i_head.x;
            end
            spt_pkg::SEG_Y: begin
                w_len_m1 = 2'd0;
                w_byte   = i_head.y;
            end
            default: begin
                w_len_m1 = 2'd2;
                w_byte   = spt_pkg::open_byte(r_sub);
            end
        endcase
        w_seg_end = (r_sub == w_len_m1);
        w_seg_bit = spt_pkg::NUM_SEG'(1) << w_seg;
        w_rest    = w_seg_end ? (w_pend & ~w_seg_bit) : w_pend;
        w_last    = w_seg_end && (w_rest == '0);
        w_fire    = i_head_valid && (!r_valid || i_tready);
    end

    assign o_pop    = w_fire && w_last;
    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_sub   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_valid <= 1'b1;
                if (w_last) begin
                    r_done <= '0;
                    r_sub  <= '0;
                end else if (w_seg_end) begin
                    r_done <= r_done | w_seg_bit;
                    r_sub  <= '0;
                end else begin
                    r_sub  <= r_sub + 1'b1;
                end
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_data <= w_byte;
            r_last <= w_last;
        end
    end

endmodule

`default_nettype wire

/* sv/sentence_paragraph_tagger.sv */
// top level of the paragraph tagger: front end, descriptor queue, back end
// uses spt_pkg, spt_front, spt_queue, spt_back
// path: the descriptor is registered in the queue, each byte in the output register
// throughput: one item per cycle while the queue has space; the back end pops an item
//   after its last byte, the output register emitting one byte per cycle unless stalled
// reset: synchronous active-low clear of scan state, queue and output valid
`timescale 1ns / 1ps
`default_nettype none

module sentence_paragraph_tagger #(
    parameter int QUEUE_DEPTH = spt_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,    // char_code
    input  wire logic       i_s_tlast,    // end_of_text
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,    // out_byte
    output logic            o_m_tlast     // last_of_run
);

    logic           w_push, w_space, w_pop, w_head_valid;
    spt_pkg::t_desc w_desc, w_head;

    spt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_char  (i_s_tdata),
        .i_end   (i_s_tlast),
        .i_space (w_space),
        .o_ready (o_s_tready),
        .o_push  (w_push),
        .o_desc  (w_desc)
    );

    spt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_desc),
        .i_pop   (w_pop),
        .o_space (w_space),
        .o_valid (w_head_valid),
        .o_desc  (w_head)
    );

    spt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_tvalid     (o_m_tvalid),
        .i_tready     (i_m_tready),
        .o_tdata      (o_m_tdata),
        .o_tlast      (o_m_tlast)
    );

endmodule

`default_nettype wire
